[hw/rtl/ptag_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ptag_pkg: shared types and constants of the padded tensor address generator
// Field widths, register index codes, layout order codes and the order decode.
// ----------------------------------------------------------------------------
package ptag_pkg;

  // Sizing of the configuration fields.
  localparam int EXTENT_BITS = 10;
  localparam int PAD_BITS    = 4;
  localparam int NUM_DIMS    = 3;
  localparam int COORD_BITS  = 12;
  localparam int OUT_W       = 31;
  localparam int ORDER_BITS  = 3;
  localparam int DIM_W       = 2;
  localparam int INDEX_W     = 3;

  // A padded extent is extent + 2 * pad; this width always holds it.
  localparam int P_BITS = ((EXTENT_BITS > PAD_BITS + 1) ? EXTENT_BITS : PAD_BITS + 1) + 1;
  // Signed width for the bounds compare of coordinate, pad and extent.
  localparam int CMP_W  = ((COORD_BITS > P_BITS) ? COORD_BITS : P_BITS) + 2;
  // Configuration data carries the widest register.
  localparam int CFG_W  = (EXTENT_BITS > PAD_BITS)
                          ? ((EXTENT_BITS > ORDER_BITS) ? EXTENT_BITS : ORDER_BITS)
                          : ((PAD_BITS > ORDER_BITS) ? PAD_BITS : ORDER_BITS);

  // Cycles the derived values need after reset or a register write.
  localparam int SETTLE_CYCLES = 5;
  localparam int SETTLE_W      = $clog2(SETTLE_CYCLES + 1);
  // Clock edges from the accepting edge of a request to the edge that takes
  // its result.
  localparam int LATENCY       = 4;

  // Register index codes.
  localparam logic [INDEX_W-1:0] REG_EXTENT0 = 3'd0;
  localparam logic [INDEX_W-1:0] REG_EXTENT1 = 3'd1;
  localparam logic [INDEX_W-1:0] REG_EXTENT2 = 3'd2;
  localparam logic [INDEX_W-1:0] REG_PAD0    = 3'd3;
  localparam logic [INDEX_W-1:0] REG_PAD1    = 3'd4;
  localparam logic [INDEX_W-1:0] REG_PAD2    = 3'd5;
  localparam logic [INDEX_W-1:0] REG_LAYOUT  = 3'd6;

  // Layout order codes, fastest dimension first.
  localparam logic [ORDER_BITS-1:0] ORDER_012 = 3'd0;
  localparam logic [ORDER_BITS-1:0] ORDER_021 = 3'd1;
  localparam logic [ORDER_BITS-1:0] ORDER_102 = 3'd2;
  localparam logic [ORDER_BITS-1:0] ORDER_120 = 3'd3;
  localparam logic [ORDER_BITS-1:0] ORDER_201 = 3'd4;
  localparam logic [ORDER_BITS-1:0] ORDER_210 = 3'd5;

  typedef logic [DIM_W-1:0] dim_t;
  // Element 0 is the fastest dimension.
  typedef dim_t [NUM_DIMS-1:0] order_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] coord0;
    logic signed [COORD_BITS-1:0] coord1;
    logic signed [COORD_BITS-1:0] coord2;
  } req_t;

  typedef struct packed {
    logic [OUT_W-1:0] entry_offset;
    logic             out_of_bounds;
    logic [OUT_W-1:0] data_offset;
    logic [OUT_W-1:0] memory_size;
    logic [OUT_W-1:0] entry_count;
  } rsp_t;

  // Decode a layout code into its dimension sequence; unused codes act as 0,1,2.
  function automatic order_t order_of(input logic [ORDER_BITS-1:0] code);
    order_t o;
    unique case (code)
      ORDER_012: o = {2'd2, 2'd1, 2'd0};
      ORDER_021: o = {2'd1, 2'd2, 2'd0};
      ORDER_102: o = {2'd2, 2'd0, 2'd1};
      ORDER_120: o = {2'd0, 2'd2, 2'd1};
      ORDER_201: o = {2'd1, 2'd0, 2'd2};
      ORDER_210: o = {2'd0, 2'd1, 2'd2};
      default:   o = {2'd2, 2'd1, 2'd0};
    endcase
    return o;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/padded_tensor_address_gen.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// padded_tensor_address_gen: address generator for a padded 3-D tensor
// Maps signed 3-D locations to linear offsets of a symmetrically padded
// tensor whose dimension order is set by a register.
// ----------------------------------------------------------------------------
//  Channel   Handshake                 Payload
//  request   start / busy (in / out)   request: coord0, coord1, coord2
//  result    done strobe (out)         result: entry_offset ... entry_count
//  config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
//  One request is taken per cycle while busy is low; it passes through the four
//  pipeline registers (capture, bounds check, stride multiply, sum and select),
//  and the done strobe rises with the last of them.
//  Strides, memory size, data offset and entry count come from a 5-stage
//  registered multiply chain; busy stays high after reset and after each
//  register write while that chain settles.
//  Reset is synchronous and active high. The receiver cannot stall: each
//  result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module padded_tensor_address_gen import ptag_pkg::*; (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  output logic                busy,
  input  wire req_t           request,
  output logic                done,
  output rsp_t                result,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire [INDEX_W-1:0]   cfg_index,
  input  wire [CFG_W-1:0]     cfg_data
);

  // Configuration registers.
  logic [EXTENT_BITS-1:0] ext_r [NUM_DIMS];
  logic [PAD_BITS-1:0]    pad_r [NUM_DIMS];
  logic [ORDER_BITS-1:0]  layout_order;
  logic [SETTLE_W-1:0]    settle_cnt;
  logic                   cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign busy      = (settle_cnt != '0);

  // Register writes; unknown indexes are ignored but still restart the settle.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < NUM_DIMS; d++) begin
        ext_r[d] <= EXTENT_BITS'(1);
        pad_r[d] <= '0;
      end
      layout_order <= ORDER_012;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_EXTENT0: ext_r[0] <= cfg_data[EXTENT_BITS-1:0];
        REG_EXTENT1: ext_r[1] <= cfg_data[EXTENT_BITS-1:0];
        REG_EXTENT2: ext_r[2] <= cfg_data[EXTENT_BITS-1:0];
        REG_PAD0:    pad_r[0] <= cfg_data[PAD_BITS-1:0];
        REG_PAD1:    pad_r[1] <= cfg_data[PAD_BITS-1:0];
        REG_PAD2:    pad_r[2] <= cfg_data[PAD_BITS-1:0];
        REG_LAYOUT:  layout_order <= cfg_data[ORDER_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Settle counter holds off requests while the derived values update.
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      settle_cnt <= SETTLE_W'(SETTLE_CYCLES);
    end else if (settle_cnt != '0) begin
      settle_cnt <= settle_cnt - 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Derived value chain of registered stages; the multiplies are spread over them.
  // ---------------------------------------------------------------------------
  logic [P_BITS-1:0] padded [NUM_DIMS];

  // Padded extent of each dimension.
  always_comb begin
    for (int d = 0; d < NUM_DIMS; d++) begin
      padded[d] = P_BITS'(ext_r[d]) + (P_BITS'(pad_r[d]) << 1);
    end
  end

  // Pick the padded extent of a dimension chosen by the layout.
  function automatic logic [P_BITS-1:0] pick_padded(input dim_t dim,
                                                    input logic [P_BITS-1:0] p0,
                                                    input logic [P_BITS-1:0] p1,
                                                    input logic [P_BITS-1:0] p2);
    logic [P_BITS-1:0] v;
    case (dim)
      2'd0:    v = p0;
      2'd1:    v = p1;
      default: v = p2;
    endcase
    return v;
  endfunction

  // Stage one: decode order, sort padded extents, first extent product.
  order_t                  s1_order;
  logic [P_BITS-1:0]       s1_pf0, s1_pf1, s1_pf2;
  logic [OUT_W-1:0]        s1_e01;
  logic [2*EXTENT_BITS-1:0] e01_full;
  order_t                  order_now;

  assign order_now = order_of(layout_order);
  assign e01_full  = ext_r[0] * ext_r[1];

  always_ff @(posedge clk) begin
    s1_order <= order_now;
    s1_pf0   <= pick_padded(order_now[0], padded[0], padded[1], padded[2]);
    s1_pf1   <= pick_padded(order_now[1], padded[0], padded[1], padded[2]);
    s1_pf2   <= pick_padded(order_now[2], padded[0], padded[1], padded[2]);
    s1_e01   <= OUT_W'(e01_full);
  end

  // Stage two: stride of the slowest dimension and the entry count.
  order_t               s2_order;
  logic [P_BITS-1:0]    s2_pf0, s2_pf2;
  logic [OUT_W-1:0]     s2_top_stride;
  logic [OUT_W-1:0]     s2_count;
  logic [2*P_BITS-1:0]  top_full;
  logic [OUT_W+EXTENT_BITS-1:0] count_full;

  assign top_full   = s1_pf0 * s1_pf1;
  assign count_full = s1_e01 * ext_r[2];

  always_ff @(posedge clk) begin
    s2_order      <= s1_order;
    s2_pf0        <= s1_pf0;
    s2_pf2        <= s1_pf2;
    s2_top_stride <= OUT_W'(top_full);
    s2_count      <= OUT_W'(count_full);
  end

  // Stage three: place strides by dimension, total padded size.
  logic [OUT_W-1:0] stride [NUM_DIMS];
  logic [OUT_W-1:0] mem_size;
  logic [OUT_W-1:0] s3_count;
  logic [OUT_W+P_BITS-1:0] total_full;

  assign total_full = s2_top_stride * s2_pf2;

  always_ff @(posedge clk) begin
    for (int d = 0; d < NUM_DIMS; d++) begin
      if (s2_order[0] == DIM_W'(d)) begin
        stride[d] <= OUT_W'(1);
      end else if (s2_order[1] == DIM_W'(d)) begin
        stride[d] <= OUT_W'(s2_pf0);
      end else begin
        stride[d] <= s2_top_stride;
      end
    end
    mem_size <= OUT_W'(total_full);
    s3_count <= s2_count;
  end

  // Stage four: padding weight of each dimension.
  logic [OUT_W-1:0]          pad_weight [NUM_DIMS];
  logic [OUT_W+PAD_BITS-1:0] pad_weight_full [NUM_DIMS];
  logic [OUT_W-1:0]          s4_count;

  always_comb begin
    for (int d = 0; d < NUM_DIMS; d++) begin
      pad_weight_full[d] = pad_r[d] * stride[d];
    end
  end

  always_ff @(posedge clk) begin
    for (int d = 0; d < NUM_DIMS; d++) begin
      pad_weight[d] <= pad_weight_full[d][OUT_W-1:0];
    end
    s4_count <= s3_count;
  end

  // Stage five: data offset of the first real entry.
  logic [OUT_W-1:0] data_off;
  logic [OUT_W-1:0] entry_cnt;

  always_ff @(posedge clk) begin
    data_off  <= pad_weight[0] + pad_weight[1] + pad_weight[2];
    entry_cnt <= s4_count;
  end

  // ---------------------------------------------------------------------------
  // Request pipeline.
  // ---------------------------------------------------------------------------
  logic                         a_valid, b_valid, c_valid;
  logic signed [COORD_BITS-1:0] a_coord [NUM_DIMS];
  logic [P_BITS-1:0]            b_idx [NUM_DIMS];
  logic                         b_oob, c_oob;
  logic [OUT_W-1:0]             c_prod [NUM_DIMS];
  logic                         accept;

  assign accept = start && !busy;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      done    <= 1'b0;
    end else begin
      a_valid <= accept;
      b_valid <= a_valid;
      c_valid <= b_valid;
      done    <= c_valid;
    end
  end

  // Capture the request.
  always_ff @(posedge clk) begin
    a_coord[0] <= request.coord0;
    a_coord[1] <= request.coord1;
    a_coord[2] <= request.coord2;
  end

  // Bounds check and padded index per dimension.
  logic [P_BITS-1:0] idx_next [NUM_DIMS];
  logic              oob_next;

  always_comb begin
    logic signed [CMP_W-1:0] cw;
    logic signed [CMP_W-1:0] padw;
    logic signed [CMP_W-1:0] extw;
    logic signed [CMP_W-1:0] lo;
    logic signed [CMP_W-1:0] hi;
    oob_next = 1'b0;
    for (int d = 0; d < NUM_DIMS; d++) begin
      cw   = CMP_W'(a_coord[d]);
      padw = signed'(CMP_W'(pad_r[d]));
      extw = signed'(CMP_W'(ext_r[d]));
      lo   = cw + padw;
      hi   = extw + padw;
      if (lo < 0 || cw >= hi) begin
        oob_next = 1'b1;
      end
      idx_next[d] = lo[P_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int d = 0; d < NUM_DIMS; d++) begin
      b_idx[d] <= idx_next[d];
    end
    b_oob <= oob_next;
  end

  // Stride multiply per dimension.
  logic [OUT_W+P_BITS-1:0] prod_full [NUM_DIMS];

  always_comb begin
    for (int d = 0; d < NUM_DIMS; d++) begin
      prod_full[d] = b_idx[d] * stride[d];
    end
  end

  always_ff @(posedge clk) begin
    for (int d = 0; d < NUM_DIMS; d++) begin
      c_prod[d] <= prod_full[d][OUT_W-1:0];
    end
    c_oob <= b_oob;
  end

  // Sum, force zero when out of bounds, and register the result.
  always_ff @(posedge clk) begin
    result.entry_offset  <= c_oob ? '0 : (c_prod[0] + c_prod[1] + c_prod[2]);
    result.out_of_bounds <= c_oob;
    result.data_offset   <= data_off;
    result.memory_size   <= mem_size;
    result.entry_count   <= entry_cnt;
  end

endmodule
`default_nettype wire

[hw/rtl/ptag_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ptag_checker: port-level checks for the padded tensor address generator
// Watches latency, the zero offset rule and the settle hold-off after writes.
// ----------------------------------------------------------------------------
module ptag_checker import ptag_pkg::*; (
  input wire               clk,
  input wire               rst,
  input wire               start,
  input wire               busy,
  input wire req_t         request,
  input wire               done,
  input wire rsp_t         result,
  input wire               cfg_valid,
  input wire               cfg_ready,
  input wire [INDEX_W-1:0] cfg_index,
  input wire [CFG_W-1:0]   cfg_data
);

  // Every accepted request produces a result after the fixed latency.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("accepted request produced no result after the latency");

  // No result appears without a request accepted one latency earlier.
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 4))
    else $error("result strobe without a matching request");

  // An out-of-bounds location reports a zero offset.
  assert property (@(posedge clk) disable iff (rst)
    (done && result.out_of_bounds) |-> (result.entry_offset == '0))
    else $error("out-of-bounds result with a nonzero offset");

  // A register write holds off requests while derived values settle.
  assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> busy)
    else $error("requests not held off after a register write");

endmodule

bind padded_tensor_address_gen ptag_checker u_ptag_checker (.*);
`default_nettype wire
